### hdl/omis_pkg.sv
// Package for the one-insertion mismatch scan: payload structs, the item class
// passed from the front to the back, and the scan constants. No dependencies.
`default_nettype none

package omis_pkg;

	// Count and field widths
	localparam int unsigned CNT_W  = 11;
	localparam int unsigned GAP_W  = 12;
	localparam int unsigned BASE_W = 8;

	// Counter saturation value and minimum-gap reset value
	localparam logic [CNT_W-1:0]        CNT_MAX   = 11'h7FF;
	localparam logic signed [GAP_W-1:0] GAP_RESET = 12'sd2047;

	// Reset value of the mismatch limit
	localparam logic [CNT_W-1:0] LIMIT_RESET = 11'd2;

	// Configuration register index, taken from paddr[2]
	localparam logic REG_DIFF_LIMIT = 1'b0;

	// Input item
	typedef struct packed {
		logic [BASE_W-1:0] read_base;
		logic [BASE_W-1:0] read_next_base;
		logic [BASE_W-1:0] ref_base;
		logic              last_pair;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic             match_found;
		logic             over_limit;
		logic [CNT_W-1:0] min_diff;
	} out_item_t;

	// Classified item: which compares missed, and whether it closes the read
	typedef struct packed {
		logic left_miss;
		logic right_miss;
		logic last;
	} class_t;

endpackage

`default_nettype wire

### hdl/omis_front.sv
// Front of the mismatch scan: accepts input items, compares bases and holds
// the classified item in one register stage. Depends on omis_pkg.
`default_nettype none

module omis_front import omis_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	output logic          cls_valid,
	input  wire logic     cls_ready,
	output class_t        cls_data
);

	logic   valid_s1;
	class_t cls_s1;

	// Take a new item when the stage is empty or drains this cycle
	assign in_ready = !valid_s1 || cls_ready;

	// Hold the valid flag of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Classify: left compare, right compare, end of read
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cls_s1.left_miss  <= in_data.read_base != in_data.ref_base;
			cls_s1.right_miss <= in_data.read_next_base != in_data.ref_base;
			cls_s1.last       <= in_data.last_pair;
		end
	end

	assign cls_valid = valid_s1;
	assign cls_data  = cls_s1;

endmodule

`default_nettype wire

### hdl/omis_queue.sv
// Two-entry queue of classified items between the front and the back of the
// mismatch scan. Depends on omis_pkg.
`default_nettype none

module omis_queue import omis_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push_valid,
	output logic        push_ready,
	input  wire class_t push_data,
	output logic        pop_valid,
	input  wire logic   pop_ready,
	output class_t      pop_data
);

	class_t     entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### hdl/omis_back.sv
// Back of the mismatch scan: running counts and minimum gaps, the end-of-read
// decision and the result register. Depends on omis_pkg.
`default_nettype none

module omis_back import omis_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CNT_W-1:0] diff_limit,
	input  wire logic             cls_valid,
	output logic                  cls_ready,
	input  wire class_t           cls_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output out_item_t             out_data
);

	logic [CNT_W-1:0]        pos_q;
	logic [CNT_W-1:0]        left_q;
	logic [CNT_W-1:0]        right_q;
	logic signed [GAP_W-1:0] best_any_q;
	logic signed [GAP_W-1:0] best_loose_q;
	logic signed [GAP_W-1:0] best_tight_q;
	logic                    any_seen_q;
	logic                    loose_seen_q;
	logic                    tight_seen_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	logic                    take;
	logic [CNT_W-1:0]        pos_n;
	logic [CNT_W-1:0]        left_n;
	logic [CNT_W-1:0]        right_n;
	logic signed [GAP_W-1:0] gap;
	logic [GAP_W-1:0]        lim12;
	logic                    loose_ok;
	logic                    tight_ok;

	logic [GAP_W-1:0]        rtot;
	logic                    over;
	logic                    seen_sel;
	logic signed [GAP_W-1:0] best_sel;
	logic signed [13:0]      match_sum;
	logic signed [13:0]      any_sum;
	logic [CNT_W-1:0]        cap;
	logic [CNT_W-1:0]        md;
	out_item_t               res;

	// Stall only a closing item while an untaken result sits in the register
	assign cls_ready = !cls_data.last || !out_valid_q || out_ready;
	assign take      = cls_valid && cls_ready;

	// Saturating counter updates
	always_comb begin
		pos_n   = (pos_q != CNT_MAX) ? pos_q + 11'd1 : pos_q;
		left_n  = (cls_data.left_miss && left_q != CNT_MAX) ? left_q + 11'd1 : left_q;
		right_n = (cls_data.right_miss && right_q != CNT_MAX) ? right_q + 11'd1 : right_q;
		gap     = $signed({1'b0, left_n}) - $signed({1'b0, right_n});
		lim12   = {1'b0, diff_limit};
		loose_ok = {1'b0, left_n} <= lim12;
		tight_ok = ({1'b0, left_n} + 12'd1) <= lim12;
	end

	// End-of-read decision from the state before this item
	always_comb begin
		rtot      = {1'b0, right_q} + {11'd0, cls_data.right_miss};
		over      = (pos_q == '0)
			|| (({1'b0, left_q} + {11'd0, cls_data.right_miss}) > lim12);
		seen_sel  = cls_data.right_miss ? tight_seen_q : loose_seen_q;
		best_sel  = cls_data.right_miss ? best_tight_q : best_loose_q;
		match_sum = {{2{best_sel[GAP_W-1]}}, best_sel} + $signed({2'b00, rtot});
		any_sum   = {{2{best_any_q[GAP_W-1]}}, best_any_q} + $signed({2'b00, rtot});
		cap       = (diff_limit == CNT_MAX) ? CNT_MAX : diff_limit + 11'd1;
		md        = cap;
		if (!over && any_seen_q) begin
			if (any_sum < 14'sd0) begin
				md = '0;
			end else if (any_sum < $signed({3'b000, cap})) begin
				md = any_sum[CNT_W-1:0];
			end
		end
		res.match_found = seen_sel && (match_sum <= $signed({3'b000, diff_limit}));
		res.over_limit  = over;
		res.min_diff    = md;
	end

	// Advance the scan state; clear it after the closing item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			left_q       <= '0;
			right_q      <= '0;
			best_any_q   <= GAP_RESET;
			best_loose_q <= GAP_RESET;
			best_tight_q <= GAP_RESET;
			any_seen_q   <= 1'b0;
			loose_seen_q <= 1'b0;
			tight_seen_q <= 1'b0;
		end else if (take) begin
			if (cls_data.last) begin
				pos_q        <= '0;
				left_q       <= '0;
				right_q      <= '0;
				best_any_q   <= GAP_RESET;
				best_loose_q <= GAP_RESET;
				best_tight_q <= GAP_RESET;
				any_seen_q   <= 1'b0;
				loose_seen_q <= 1'b0;
				tight_seen_q <= 1'b0;
			end else begin
				pos_q      <= pos_n;
				left_q     <= left_n;
				right_q    <= right_n;
				any_seen_q <= 1'b1;
				if (!any_seen_q || gap < best_any_q) begin
					best_any_q <= gap;
				end
				if (loose_ok) begin
					loose_seen_q <= 1'b1;
					if (!loose_seen_q || gap < best_loose_q) begin
						best_loose_q <= gap;
					end
				end
				if (tight_ok) begin
					tight_seen_q <= 1'b1;
					if (!tight_seen_q || gap < best_tight_q) begin
						best_tight_q <= gap;
					end
				end
			end
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && cls_data.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (take && cls_data.last) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

### hdl/one_insertion_mismatch_scan_core.sv
// Top level of the one-insertion mismatch scan: APB limit register, front
// classifier, item queue and scan back end. Depends on omis_pkg, omis_front,
// omis_queue and omis_back.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    in_data   (in_item_t: read bases, ref base, last)
//   out      out_valid / out_ready  out_data  (out_item_t: match, over, min_diff)
//   cfg      APB psel/penable       pwdata/prdata, paddr[2] selects diff_limit
//
// One item per cycle sustained while no closing item is stalled. The last item of a read
// passes from the front register into the queue and from the queue into the back end,
// which loads its result into the result register that drives out_valid.
// The running counts and minimums in the back end update once per item and are cleared by the closing item.
// Reset clears the scan state and sets diff_limit to 2.
// A full result register stalls only the closing item; the queue lets the
// front keep taking items meanwhile, until it holds two items.
`default_nettype none

module one_insertion_mismatch_scan_core import omis_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [CNT_W-1:0] diff_limit_q;
	logic             f_valid;
	logic             f_ready;
	class_t           f_data;
	logic             b_valid;
	logic             b_ready;
	class_t           b_data;

	assign pready = 1'b1;

	// Write the limit register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_DIFF_LIMIT) begin
			diff_limit_q <= pwdata[CNT_W-1:0];
		end
	end

	// Read back the limit register
	assign prdata = (paddr[2] == REG_DIFF_LIMIT) ? {21'd0, diff_limit_q} : 32'd0;

	omis_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cls_valid (f_valid),
		.cls_ready (f_ready),
		.cls_data  (f_data)
	);

	omis_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	omis_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.diff_limit (diff_limit_q),
		.cls_valid  (b_valid),
		.cls_ready  (b_ready),
		.cls_data   (b_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire
